/* rtl/core/assert_macros.svh */
// assertion macros used by the sequencer top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequence is checked in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tvp_pkg.sv */
// types and constants for the timed valve and pump sequencer
package tvp_pkg;

	// sequencer stages
	typedef enum logic [2:0] {
		STG_IDLE        = 3'd0,
		STG_V3_CLOSED   = 3'd1,
		STG_V3_OPEN     = 3'd2,
		STG_FREEZE      = 3'd3,
		STG_POST_FREEZE = 3'd4,
		STG_FINAL_FREEZE = 3'd5,
		STG_FINAL_RUN   = 3'd6
	} stage_t;

	// configuration register indexes
	localparam logic [1:0] CFG_STAGE_TICKS   = 2'd0;
	localparam logic [1:0] CFG_BLOCK_REPEATS = 2'd1;
	localparam logic [1:0] CFG_PULSE_TICKS   = 2'd2;

	localparam logic [31:0] STAGE_TICKS_RST   = 32'd300000;
	localparam logic [7:0]  BLOCK_REPEATS_RST = 8'd3;
	localparam logic [15:0] PULSE_TICKS_RST   = 16'd1000;

	// key codes
	localparam logic [7:0] KEY_STOP     = 8'h30; // '0'
	localparam logic [7:0] KEY_START    = 8'h31; // '1'
	localparam logic [7:0] KEY_PULSE_V1 = 8'h32; // '2'
	localparam logic [7:0] KEY_PULSE_V2 = 8'h33; // '3'
	localparam logic [7:0] KEY_PULSE_V3 = 8'h34; // '4'
	localparam logic [7:0] KEY_PUMP_ALT = 8'h35; // '5'
	localparam logic [7:0] KEY_SEQUENCE = 8'h66; // 'f'
	localparam logic [7:0] KEY_LEAK     = 8'h6c; // 'l'
	localparam logic [7:0] KEY_PUMP     = 8'h74; // 't'

	// relay bit positions, also the pulse target codes
	localparam logic [1:0] RLY_V1   = 2'd0;
	localparam logic [1:0] RLY_V2   = 2'd1;
	localparam logic [1:0] RLY_V3   = 2'd2;
	localparam logic [1:0] RLY_PUMP = 2'd3;

	// relay patterns, pump in bit 3
	localparam logic [3:0] RELAYS_HALT   = 4'b0111;
	localparam logic [3:0] RELAYS_MANUAL = 4'b0100;
	localparam logic [3:0] RELAYS_SEQ    = 4'b1100;
	localparam logic [3:0] RELAYS_LEAK   = 4'b1011;
	localparam logic [3:0] RELAYS_FLUSH  = 4'b1000;

	typedef struct packed {
		logic [31:0] stage_ticks;
		logic [7:0]  block_repeats;
		logic [15:0] pulse_ticks;
	} cfg_t;

	typedef struct packed {
		stage_t      stage;
		logic [31:0] elapsed;
		logic [7:0]  block_count;
		logic [3:0]  relays;
		logic [15:0] pulse_left;
		logic [1:0]  pulse_target;
	} state_t;

	typedef struct packed {
		logic [3:0] relays;
		logic [2:0] stage;
		logic [7:0] block_index;
		logic       pulse_busy;
		logic       key_dropped;
	} result_t;

	function automatic logic is_run_stage(stage_t s);
		return (s == STG_V3_CLOSED) || (s == STG_V3_OPEN) ||
			(s == STG_POST_FREEZE) || (s == STG_FINAL_RUN);
	endfunction

endpackage

/* rtl/core/tvp_cfg.sv */
// configuration registers of the sequencer
module tvp_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	output tvp_pkg::cfg_t cfg
);
	import tvp_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stage_ticks   <= STAGE_TICKS_RST;
			cfg_q.block_repeats <= BLOCK_REPEATS_RST;
			cfg_q.pulse_ticks   <= PULSE_TICKS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_STAGE_TICKS:   cfg_q.stage_ticks   <= cfg_data;
				CFG_BLOCK_REPEATS: cfg_q.block_repeats <= cfg_data[7:0];
				CFG_PULSE_TICKS:   cfg_q.pulse_ticks   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

/* rtl/core/tvp_core.sv */
// sequencer state registers and next-state logic for one request
module tvp_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic             command,
	input  logic [7:0]       key,
	input  tvp_pkg::cfg_t    cfg,
	output tvp_pkg::result_t result,
	output tvp_pkg::state_t  state
);
	import tvp_pkg::*;

	state_t     cur_q;
	state_t     nxt;
	logic       run;
	logic       check;
	logic       dropped;
	logic       pulse_go;
	logic [1:0] pulse_sel;
	logic [7:0] bc_inc;

	assign run = is_run_stage(cur_q.stage);

	// next state for a tick or a key
	always_comb begin
		nxt       = cur_q;
		check     = 1'b0;
		dropped   = 1'b0;
		pulse_go  = 1'b0;
		pulse_sel = RLY_PUMP;
		bc_inc    = (cur_q.block_count != 8'hff) ? cur_q.block_count + 8'd1
			: cur_q.block_count;
		if (!command) begin
			// tick: count, pulse countdown, then stage check
			if (run && (cur_q.elapsed != 32'hffff_ffff)) begin
				nxt.elapsed = cur_q.elapsed + 32'd1;
			end
			check = 1'b1;
			if (cur_q.pulse_left != 16'd0) begin
				nxt.pulse_left = cur_q.pulse_left - 16'd1;
				if (nxt.pulse_left == 16'd0) begin
					nxt.relays[cur_q.pulse_target] = 1'b0;
				end else begin
					check = 1'b0;
				end
			end
			if (check && run && (nxt.elapsed >= cfg.stage_ticks)) begin
				unique case (cur_q.stage)
					STG_V3_CLOSED: begin
						nxt.stage       = STG_V3_OPEN;
						nxt.relays[RLY_V3] = 1'b0;
						nxt.elapsed     = 32'd0;
					end
					STG_V3_OPEN: begin
						nxt.stage  = STG_FREEZE;
						nxt.relays = RELAYS_HALT;
					end
					STG_POST_FREEZE: begin
						nxt.block_count = bc_inc;
						if (bc_inc < cfg.block_repeats) begin
							nxt.stage   = STG_V3_CLOSED;
							nxt.relays  = RELAYS_SEQ;
							nxt.elapsed = 32'd0;
						end else begin
							nxt.stage  = STG_FINAL_FREEZE;
							nxt.relays = RELAYS_HALT;
						end
					end
					default: begin
						nxt.stage  = STG_IDLE;
						nxt.relays = RELAYS_HALT;
					end
				endcase
			end
		end else if (cur_q.pulse_left != 16'd0) begin
			// key during a held pulse is dropped
			dropped = 1'b1;
		end else if (cur_q.stage == STG_FREEZE) begin
			nxt.stage   = STG_POST_FREEZE;
			nxt.relays  = RELAYS_FLUSH;
			nxt.elapsed = 32'd0;
		end else if (cur_q.stage == STG_FINAL_FREEZE) begin
			nxt.stage   = STG_FINAL_RUN;
			nxt.relays  = RELAYS_FLUSH;
			nxt.elapsed = 32'd0;
		end else begin
			// key commands
			unique case (key)
				KEY_START: begin
					nxt.stage  = STG_IDLE;
					nxt.relays = RELAYS_MANUAL;
				end
				KEY_STOP: begin
					nxt.stage  = STG_IDLE;
					nxt.relays = RELAYS_HALT;
				end
				KEY_SEQUENCE: begin
					nxt.block_count = 8'd0;
					nxt.stage       = STG_V3_CLOSED;
					nxt.relays      = RELAYS_SEQ;
					nxt.elapsed     = 32'd0;
				end
				KEY_LEAK: nxt.relays = RELAYS_LEAK;
				KEY_PUMP, KEY_PUMP_ALT: begin
					pulse_go  = 1'b1;
					pulse_sel = RLY_PUMP;
				end
				KEY_PULSE_V1: begin
					pulse_go  = 1'b1;
					pulse_sel = RLY_V1;
				end
				KEY_PULSE_V2: begin
					pulse_go  = 1'b1;
					pulse_sel = RLY_V2;
				end
				KEY_PULSE_V3: begin
					pulse_go  = 1'b1;
					pulse_sel = RLY_V3;
				end
				default: ;
			endcase
			// pulse start, a zero length just drops the relay
			if (pulse_go) begin
				nxt.pulse_target = pulse_sel;
				nxt.pulse_left   = cfg.pulse_ticks;
				nxt.relays[pulse_sel] = (cfg.pulse_ticks != 16'd0);
			end
		end
	end

	// state update when a request leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.stage        <= STG_IDLE;
			cur_q.elapsed      <= 32'd0;
			cur_q.block_count  <= 8'd0;
			cur_q.relays       <= RELAYS_HALT;
			cur_q.pulse_left   <= 16'd0;
			cur_q.pulse_target <= RLY_V1;
		end else if (step_en) begin
			cur_q <= nxt;
		end
	end

	// result is the state after the request
	assign result.relays      = nxt.relays;
	assign result.stage       = nxt.stage;
	assign result.block_index = nxt.block_count;
	assign result.pulse_busy  = (nxt.pulse_left != 16'd0);
	assign result.key_dropped = dropped;
	assign state              = cur_q;
endmodule

/* rtl/core/timed_valve_pump_sequencer.sv */
// path: a request is held in the input register and moves into the result register when
// that is free; its result then shows at the outputs until it is taken
// throughput: one request per cycle, the input register and the result register
// each move on whenever the stage after them is free
// reset: arst_n clears both valid bits and the sequencer state (idle, valves high,
// pump low) and loads the configuration registers with their default values
`include "assert_macros.svh"

module timed_valve_pump_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valve_one,
	output logic        valve_two,
	output logic        valve_three,
	output logic        pump_on,
	output logic [2:0]  stage,
	output logic [7:0]  block_index,
	output logic        pulse_busy,
	output logic        key_dropped
);
	import tvp_pkg::*;

	cfg_t       cfg;
	result_t    result;
	state_t     state;
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] key_s1;
	logic       out_valid_q;
	result_t    result_q;
	logic       advance;

	tvp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input stage moves into the result register when that is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			key_s1     <= key;
		end
	end

	tvp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.command (command_s1),
		.key     (key_s1),
		.cfg     (cfg),
		.result  (result),
		.state   (state)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign valve_one   = result_q.relays[RLY_V1];
	assign valve_two   = result_q.relays[RLY_V2];
	assign valve_three = result_q.relays[RLY_V3];
	assign pump_on     = result_q.relays[RLY_PUMP];
	assign stage       = result_q.stage;
	assign block_index = result_q.block_index;
	assign pulse_busy  = result_q.pulse_busy;
	assign key_dropped = result_q.key_dropped;

	// a held pulse keeps its relay high
	`ASSERT_CLK(a_pulse_relay_high, (state.pulse_left != 16'd0) |-> state.relays[state.pulse_target], "pulse held with its relay low")
	// a dropped key only happens while a pulse is still held
	`ASSERT_CLK(a_drop_busy, (out_valid_q && result_q.key_dropped) |-> result_q.pulse_busy, "key dropped without a held pulse")
	// a request leaving the input stage shows up as a result
	`ASSERT_NEXT(a_advance_out, advance, out_valid_q, "request lost between stages")
endmodule

/* verif/timed_valve_pump_sequencer_test.sv */
// self-checking testbench for the timed valve and pump sequencer
`timescale 1ns / 1ps

module timed_valve_pump_sequencer_test;
	import tvp_pkg::*;

	typedef struct packed {
		logic       is_key;
		logic [7:0] code;
	} request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = CFG_STAGE_TICKS;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [7:0]  key = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        valve_one;
	logic        valve_two;
	logic        valve_three;
	logic        pump_on;
	logic [2:0]  stage;
	logic [7:0]  block_index;
	logic        pulse_busy;
	logic        key_dropped;

	// configuration shadow
	logic [31:0] cfg_stage_ticks = STAGE_TICKS_RST;
	logic [7:0]  cfg_block_repeats = BLOCK_REPEATS_RST;
	logic [15:0] cfg_pulse_ticks = PULSE_TICKS_RST;

	// predicted sequencer state, at its reset values
	stage_t      cur_stage = STG_IDLE;
	logic [31:0] elapsed = '0;
	logic [7:0]  blocks_done = '0;
	logic [3:0]  relays = RELAYS_HALT;
	logic [15:0] pulse_left = '0;
	logic [1:0]  pulse_target = RLY_V1;

	request_t pending_requests[$];
	result_t  predicted_status[$];
	int       mismatch_count = 0;
	bit       steady = 1'b0;
	int       stall_requests = 0;
	int       stall_served = 0;
	int       stall_left = 0;

	// keys that pulse a relay or start the leak test
	logic [7:0] action_keys[6] = '{KEY_PUMP, KEY_PUMP_ALT, KEY_PULSE_V1,
		KEY_PULSE_V2, KEY_PULSE_V3, KEY_LEAK};

	timed_valve_pump_sequencer DUT (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// one tick or key applied to the predicted state, giving the status shown after it
	function automatic result_t sequencer_step(input logic is_key, input logic [7:0] code);
		result_t    res;
		logic       running;
		logic       held;
		logic       do_pulse;
		logic [1:0] target;
		running = (cur_stage == STG_V3_CLOSED) || (cur_stage == STG_V3_OPEN) ||
			(cur_stage == STG_POST_FREEZE) || (cur_stage == STG_FINAL_RUN);
		held = 1'b0;
		do_pulse = 1'b0;
		target = RLY_V1;
		res.key_dropped = 1'b0;
		if (!is_key) begin
			if (running && elapsed != '1)
				elapsed++;
			// a held pulse blocks any stage change until it runs out
			if (pulse_left != 0) begin
				pulse_left--;
				if (pulse_left == 0)
					relays[pulse_target] = 1'b0;
				else
					held = 1'b1;
			end
			if (!held && running && elapsed >= cfg_stage_ticks) begin
				case (cur_stage)
					STG_V3_CLOSED: begin
						cur_stage = STG_V3_OPEN;
						relays[RLY_V3] = 1'b0;
						elapsed = '0;
					end
					STG_V3_OPEN: begin
						cur_stage = STG_FREEZE;
						relays = RELAYS_HALT;
					end
					STG_POST_FREEZE: begin
						if (blocks_done != 8'hff)
							blocks_done++;
						if (blocks_done < cfg_block_repeats) begin
							cur_stage = STG_V3_CLOSED;
							relays = RELAYS_SEQ;
							elapsed = '0;
						end else begin
							cur_stage = STG_FINAL_FREEZE;
							relays = RELAYS_HALT;
						end
					end
					default: begin
						cur_stage = STG_IDLE;
						relays = RELAYS_HALT;
					end
				endcase
			end
		end else if (pulse_left != 0) begin
			res.key_dropped = 1'b1;
		end else if (cur_stage == STG_FREEZE || cur_stage == STG_FINAL_FREEZE) begin
			// any key ends a freeze
			cur_stage = (cur_stage == STG_FREEZE) ? STG_POST_FREEZE : STG_FINAL_RUN;
			relays = RELAYS_FLUSH;
			elapsed = '0;
		end else begin
			case (code)
				KEY_START: begin
					cur_stage = STG_IDLE;
					relays = RELAYS_MANUAL;
				end
				KEY_STOP: begin
					cur_stage = STG_IDLE;
					relays = RELAYS_HALT;
				end
				KEY_SEQUENCE: begin
					blocks_done = '0;
					cur_stage = STG_V3_CLOSED;
					relays = RELAYS_SEQ;
					elapsed = '0;
				end
				KEY_LEAK: relays = RELAYS_LEAK;
				KEY_PUMP, KEY_PUMP_ALT: begin
					do_pulse = 1'b1;
					target = RLY_PUMP;
				end
				KEY_PULSE_V1: begin
					do_pulse = 1'b1;
					target = RLY_V1;
				end
				KEY_PULSE_V2: begin
					do_pulse = 1'b1;
					target = RLY_V2;
				end
				KEY_PULSE_V3: begin
					do_pulse = 1'b1;
					target = RLY_V3;
				end
				default: ;
			endcase
			// a zero pulse length drops the relay at once
			if (do_pulse) begin
				pulse_target = target;
				if (cfg_pulse_ticks == 0) begin
					relays[target] = 1'b0;
					pulse_left = '0;
				end else begin
					relays[target] = 1'b1;
					pulse_left = cfg_pulse_ticks;
				end
			end
		end
		res.relays = relays;
		res.stage = cur_stage;
		res.block_index = blocks_done;
		res.pulse_busy = (pulse_left != 0);
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// request driver, predicting each request as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				predicted_status.push_back(sequencer_step(command, key));
			if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
				in_valid <= 1'b1;
				command <= pending_requests[0].is_key;
				key <= pending_requests[0].code;
				void'(pending_requests.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor with random and long back-pressure
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_status.size() == 0) begin
					$error("result arrived with nothing expected");
					mismatch_count++;
				end else begin
					want = predicted_status.pop_front();
					compare_field("valve_one", 8'(want.relays[RLY_V1]), 8'(valve_one));
					compare_field("valve_two", 8'(want.relays[RLY_V2]), 8'(valve_two));
					compare_field("valve_three", 8'(want.relays[RLY_V3]), 8'(valve_three));
					compare_field("pump_on", 8'(want.relays[RLY_PUMP]), 8'(pump_on));
					compare_field("stage", 8'(want.stage), 8'(stage));
					compare_field("block_index", want.block_index, block_index);
					compare_field("pulse_busy", 8'(want.pulse_busy), 8'(pulse_busy));
					compare_field("key_dropped", 8'(want.key_dropped), 8'(key_dropped));
				end
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (stall_served != stall_requests) begin
				out_ready <= 1'b0;
				stall_left <= 60;
				stall_served <= stall_requests;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 30);
			end
		end
	end

	task automatic push_tick(input int n);
		for (int i = 0; i < n; i++)
			pending_requests.push_back('{is_key: 1'b0, code: 8'($urandom_range(255))});
	endtask

	task automatic push_key(input logic [7:0] k);
		pending_requests.push_back('{is_key: 1'b1, code: k});
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_STAGE_TICKS:   cfg_stage_ticks = value;
			CFG_BLOCK_REPEATS: cfg_block_repeats = value[7:0];
			CFG_PULSE_TICKS:   cfg_pulse_ticks = value[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// wait until every request is taken and every result checked
	task automatic settle();
		while (pending_requests.size() != 0 || in_valid || predicted_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// a sequence start followed mostly by ticks, with some keys and rare aborts
	task automatic random_phase(input int n);
		int pick;
		push_key(KEY_SEQUENCE);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 65)
				push_tick(1);
			else if (pick < 75)
				push_key(action_keys[$urandom_range(5)]);
			else if (pick < 95)
				push_key(8'($urandom_range(255)));
			else if (pick < 97)
				push_key(KEY_STOP);
			else if (pick < 98)
				push_key(KEY_START);
			else
				push_key(KEY_SEQUENCE);
		end
	endtask

	// main sequence of phases
	initial begin
		int waited;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default settings: a tick, then manual start, leak test, stop
		pending_requests.push_back('{is_key: 1'b0, code: 8'h00});
		push_key(KEY_START);
		push_key(KEY_LEAK);
		push_key(KEY_STOP);
		settle();

		// one full short sequence, then a pulse with a key dropped during it
		write_register(CFG_STAGE_TICKS, 32'd1);
		write_register(CFG_BLOCK_REPEATS, 32'd1);
		write_register(CFG_PULSE_TICKS, 32'd2);
		@(negedge clk);
		push_key(KEY_SEQUENCE);
		push_tick(2);
		push_key(8'h41);
		push_tick(1);
		push_key(8'hff);
		push_tick(1);
		push_key(KEY_PULSE_V1);
		push_key(KEY_PULSE_V2);
		push_tick(2);
		settle();

		// zero stage length, zero repeats, zero pulse length
		write_register(CFG_STAGE_TICKS, 32'd0);
		write_register(CFG_BLOCK_REPEATS, 32'd0);
		write_register(CFG_PULSE_TICKS, 32'd0);
		@(negedge clk);
		push_key(KEY_SEQUENCE);
		push_tick(2);
		push_key(8'h00);
		push_tick(1);
		push_key(8'h7a);
		push_tick(1);
		push_key(KEY_PULSE_V3);
		push_key(KEY_PUMP_ALT);
		settle();

		// largest settings: a run stage that never ends in practice
		write_register(CFG_STAGE_TICKS, 32'hffff_ffff);
		write_register(CFG_BLOCK_REPEATS, 32'd255);
		write_register(CFG_PULSE_TICKS, 32'd65535);
		@(negedge clk);
		push_key(KEY_SEQUENCE);
		push_tick(3);
		push_key(KEY_STOP);
		settle();

		// random phases with short stages and pulses
		for (int p = 0; p < 6; p++) begin
			write_register(CFG_STAGE_TICKS, $urandom_range(5));
			write_register(CFG_BLOCK_REPEATS, (p == 5) ? 32'd255 : $urandom_range(3));
			write_register(CFG_PULSE_TICKS, $urandom_range(4));
			@(negedge clk);
			steady = (p == 4);
			if (p == 2)
				stall_requests++;
			random_phase(120);
			settle();
		end
		steady = 1'b0;

		waited = 0;
		while ((pending_requests.size() != 0 || in_valid || predicted_status.size() != 0)
				&& waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && predicted_status.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run limit
	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
